[hdl/msm_pkg.sv]
// Shared types, codes and constants of the multi-stack shared memory block.
`default_nettype none
package msm_pkg;

  localparam int NUM_STACKS_DEF  = 4;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int REQ_W           = 2;
  localparam int SEL_FIELD_W     = 3;
  localparam int VALUE_W         = 32;
  localparam int STATUS_W        = 3;
  localparam int CMDQ_DEPTH      = 2;
  localparam int OUTQ_DEPTH      = 4;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH = 2'd0,
    REQ_POP  = 2'd1,
    REQ_DUMP = 2'd2
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_STACK = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef struct packed {
    req_t                   req;
    logic [SEL_FIELD_W-1:0] sel;
    logic [VALUE_W-1:0]     value;
    logic                   bad;
  } cmd_t;

  typedef struct packed {
    status_t            status;
    logic [VALUE_W-1:0] value;
    logic               last;
  } res_t;

endpackage
`default_nettype wire

[hdl/multi_stack_shared_memory.sv]
// Top level of the multi-stack shared memory block.
//
//   channel  direction  handshake      payload
//   request  in         push / full    in_req_type, in_stack_sel, in_push_value
//   result   out        pop / empty    out_status, out_value, out_last
//
// Push, pop and error requests can follow each other every cycle while the result
// queue has room; a word passes the request queue, the engine's result register
// and the result queue before the result ports. A dump reads its entries one by
// one through the single memory read port. Reset clears the fill counts at once;
// memory contents are not cleared since only written entries are ever read. full
// rises when the two-word request queue is full; the engine waits while the
// four-word result queue, counting the word in flight, is full.
`default_nettype none
module multi_stack_shared_memory
  import msm_pkg::*;
#(
  parameter int NUM_STACKS  = NUM_STACKS_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  logic [REQ_W-1:0]       in_req_type,
  input  logic [SEL_FIELD_W-1:0] in_stack_sel,
  input  logic signed [VALUE_W-1:0] in_push_value,
  output logic                   empty,
  input  logic                   pop,
  output logic [STATUS_W-1:0]    out_status,
  output logic signed [VALUE_W-1:0] out_value,
  output logic                   out_last
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  res_t res;

  msm_front #(
    .NUM_STACKS (NUM_STACKS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_req_type   (in_req_type),
    .in_stack_sel  (in_stack_sel),
    .in_push_value (in_push_value),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  msm_back #(
    .NUM_STACKS  (NUM_STACKS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

  assign out_status = res.status;
  assign out_value  = res.value;
  assign out_last   = res.last;

endmodule
`default_nettype wire

[hdl/msm_fifo.sv]
// Small register-based first-in first-out queue used between the block's parts.
`default_nettype none
module msm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wr_data,
  output logic                       full,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       empty,
  output logic [$clog2(DEPTH):0]     count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH) + 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             wr_ok;
  logic             rd_ok;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rd_data = mem_r[rd_ptr_r];
  assign wr_ok   = wr_en && !full;
  assign rd_ok   = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CW'(wr_ok) - CW'(rd_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

[hdl/msm_front.sv]
// Request front end: takes words, drops unused request codes, flags bad stack numbers.
`default_nettype none
module msm_front
  import msm_pkg::*;
#(
  parameter int NUM_STACKS = NUM_STACKS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  logic [REQ_W-1:0]       in_req_type,
  input  logic [SEL_FIELD_W-1:0] in_stack_sel,
  input  logic [VALUE_W-1:0]     in_push_value,
  output logic                   cmd_valid,
  output cmd_t                   cmd,
  input  logic                   cmd_pop
);

  logic known_req;
  logic q_wr;
  logic q_empty;
  cmd_t q_wr_data;
  logic [$bits(cmd_t)-1:0] q_rd_data;
  logic [$clog2(CMDQ_DEPTH):0] q_count;

  always_comb begin
    case (in_req_type)
      REQ_PUSH, REQ_POP, REQ_DUMP: known_req = 1'b1;
      default:                     known_req = 1'b0;
    endcase
  end

  always_comb begin
    q_wr_data.req   = req_t'(in_req_type);
    q_wr_data.sel   = in_stack_sel;
    q_wr_data.value = in_push_value;
    q_wr_data.bad   = (32'(in_stack_sel) >= 32'(NUM_STACKS));
  end

  // The unused request code is accepted but never reaches the back end.
  assign q_wr = push && !full && known_req;

  msm_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_wr_data),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty),
    .count   (q_count)
  );

  assign cmd_valid = !q_empty && (q_count != '0);
  assign cmd       = cmd_t'(q_rd_data);

endmodule
`default_nettype wire

[hdl/msm_back.sv]
// Stack engine: fill counts, the shared stack memory, and the result queue.
`default_nettype none
module msm_back
  import msm_pkg::*;
#(
  parameter int NUM_STACKS  = NUM_STACKS_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic empty,
  input  logic pop,
  output res_t res
);

  localparam int SEL_W     = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int FILL_N    = 2 ** SEL_W;
  localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int MEM_WORDS = NUM_STACKS * STACK_DEPTH;
  localparam int AW        = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int OQ_CW     = $clog2(OUTQ_DEPTH) + 1;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]   fill_r [FILL_N];
  logic [VALUE_W-1:0] mem_r [MEM_WORDS];
  logic [VALUE_W-1:0] rd_data_r;

  logic               res_vld_r;
  status_t            res_status_r;
  logic               res_mem_r;
  logic               res_last_r;

  logic [AW-1:0]      dump_base_r, dump_base_nxt;
  logic [CNT_W-1:0]   dump_idx_r, dump_idx_nxt;
  logic [CNT_W-1:0]   dump_cnt_r, dump_cnt_nxt;

  logic               iss;
  status_t            iss_status;
  logic               iss_mem;
  logic               iss_last;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic               fill_we;
  logic [CNT_W-1:0]   fill_val;

  logic [SEL_W-1:0]   cur_sel;
  logic [CNT_W-1:0]   cur_cnt;
  logic [AW-1:0]      cur_base;
  logic               space;

  logic               oq_full;
  logic [OQ_CW-1:0]   oq_count;
  res_t               oq_wr_data;
  logic [$bits(res_t)-1:0] oq_rd_data;

  assign cur_sel  = cmd.sel[SEL_W-1:0];
  assign cur_cnt  = fill_r[cur_sel];
  assign cur_base = AW'(cur_sel * STACK_DEPTH);

  // The result held in the result register lands in the queue next cycle, so count it as taken.
  assign space = ({1'b0, oq_count} + (OQ_CW + 1)'(res_vld_r)) < (OQ_CW + 1)'(OUTQ_DEPTH);

  always_comb begin
    state_nxt     = state_r;
    dump_base_nxt = dump_base_r;
    dump_idx_nxt  = dump_idx_r;
    dump_cnt_nxt  = dump_cnt_r;
    cmd_pop       = 1'b0;
    iss           = 1'b0;
    iss_status    = ST_OK;
    iss_mem       = 1'b0;
    iss_last      = 1'b1;
    rd_addr       = dump_base_r + AW'(dump_idx_r);
    wr_en         = 1'b0;
    wr_addr       = cur_base + AW'(cur_cnt);
    fill_we       = 1'b0;
    fill_val      = cur_cnt;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && space) begin
          cmd_pop = 1'b1;
          iss     = 1'b1;
          if (cmd.bad) begin
            iss_status = ST_BAD_STACK;
          end else begin
            unique case (cmd.req)
              REQ_PUSH: begin
                if (cur_cnt >= CNT_W'(STACK_DEPTH)) begin
                  iss_status = ST_OVERFLOW;
                end else begin
                  wr_en    = 1'b1;
                  fill_we  = 1'b1;
                  fill_val = cur_cnt + 1'b1;
                end
              end
              REQ_POP: begin
                if (cur_cnt == '0) begin
                  iss_status = ST_UNDERFLOW;
                end else begin
                  fill_we  = 1'b1;
                  fill_val = cur_cnt - 1'b1;
                  iss_mem  = 1'b1;
                  rd_addr  = cur_base + AW'(cur_cnt - 1'b1);
                end
              end
              REQ_DUMP: begin
                if (cur_cnt == '0) begin
                  iss_status = ST_EMPTY;
                end else begin
                  iss_mem       = 1'b1;
                  rd_addr       = cur_base;
                  iss_last      = (cur_cnt == CNT_W'(1));
                  dump_base_nxt = cur_base;
                  dump_cnt_nxt  = cur_cnt;
                  dump_idx_nxt  = CNT_W'(1);
                  if (cur_cnt != CNT_W'(1)) begin
                    state_nxt = S_DUMP;
                  end
                end
              end
              default: begin
                iss = 1'b0;
              end
            endcase
          end
        end
      end
      S_DUMP: begin
        if (space) begin
          iss          = 1'b1;
          iss_mem      = 1'b1;
          iss_last     = (CNT_W'(dump_idx_r + 1'b1) == dump_cnt_r);
          dump_idx_nxt = dump_idx_r + 1'b1;
          if (iss_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      res_vld_r <= 1'b0;
      for (int i = 0; i < FILL_N; i++) begin
        fill_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      res_vld_r    <= iss;
      res_status_r <= iss_status;
      res_mem_r    <= iss_mem;
      res_last_r   <= iss_last;
      dump_base_r  <= dump_base_nxt;
      dump_idx_r   <= dump_idx_nxt;
      dump_cnt_r   <= dump_cnt_nxt;
      if (fill_we) begin
        fill_r[cur_sel] <= fill_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= cmd.value;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  always_comb begin
    oq_wr_data.status = res_status_r;
    oq_wr_data.value  = res_mem_r ? rd_data_r : '0;
    oq_wr_data.last   = res_last_r;
  end

  msm_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_vld_r),
    .wr_data (oq_wr_data),
    .full    (oq_full),
    .rd_en   (pop),
    .rd_data (oq_rd_data),
    .empty   (empty),
    .count   (oq_count)
  );

  assign res = res_t'(oq_rd_data);

  a_outq_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r |-> !oq_full)
    else $error("result queue written while full");

  a_dump_holds_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |-> !cmd_pop)
    else $error("command taken during a dump");

  a_dump_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |-> (dump_idx_r < dump_cnt_r))
    else $error("dump index ran past the fill count");

  a_issue_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    iss |=> res_vld_r)
    else $error("issued result did not reach the result stage");

  a_dump_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DUMP) && (state_nxt == S_IDLE)) |=> (res_vld_r && res_last_r))
    else $error("dump finished without a final marked word");

endmodule
`default_nettype wire
